>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit chunk allocator.
// Holds the arena geometry, the derived widths, the status codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package ffba_pkg;

   // Arena geometry.
   localparam int MAX_CHUNKS  = 1024;
   localparam int CHUNK_BYTES = 4096;

   // Fixed field widths of the request and response items.
   localparam int OP_W     = 1;
   localparam int REQ_W    = 12;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 10;
   localparam int OFFSET_W = 12;

   // Internal widths derived from the geometry.
   localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
   localparam int FILL_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
   localparam int SUM_W  = ((FILL_W > REQ_W) ? FILL_W : REQ_W) + 1;

   // Operation codes of a request item.
   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   // Status codes of a response item.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_CLEARED   = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

>>> rtl/ffba_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_req_if / ffba_rsp_if: valid/ready channels of the allocator.
// The request channel carries an operation and a size, the response channel
// a status, a chunk index and a byte offset.
// ----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [REQ_W-1:0] request_size;

   modport source (output valid, output op, output request_size, input ready);
   modport sink   (input valid, input op, input request_size, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  chunk_index;
   logic [OFFSET_W-1:0] byte_offset;

   modport source (output valid, output status, output chunk_index, output byte_offset,
                   input ready);
   modport sink   (input valid, input status, input chunk_index, input byte_offset,
                   output ready);
endinterface

>>> rtl/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram: generic single-write, single-read RAM.
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/first_fit_chunk_bump_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_chunk_bump_allocator_core: first-fit chunk bump allocator.
// Walks the open chunks in order, grants the first one with room, opens a
// new chunk when none fits, and closes all chunks on a clear.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake     Fields
//  -------  ---  ------------  --------------------------------------
//  req_ch   in   valid/ready   op, request_size
//  rsp_ch   out  valid/ready   status, chunk_index, byte_offset
//
// A clear, a refused request or an allocate with no open chunk is decided
// in the idle state and goes straight to the response. Any other allocate
// walks the fill RAM one chunk per cycle through its single read port,
// examining up to MAX_CHUNKS chunks. The response is then held until it
// is taken; no new item is accepted until then. Reset is synchronous and
// clears the open chunk count; the fill RAM needs no clearing, since only
// chunks that were opened, and so written, are read.
// ----------------------------------------------------------------------------
module first_fit_chunk_bump_allocator_core import ffba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ffba_req_if.sink   req_ch,
   ffba_rsp_if.source rsp_ch
);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [REQ_W-1:0]        size_ff, size_in;
   status_type              status_ff, status_in;
   logic [INDEX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   logic [OFFSET_W-1:0]     rsp_off_ff, rsp_off_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [FILL_W-1:0]       ram_wdata;
   logic [IDX_W-1:0]        ram_raddr;
   logic [FILL_W-1:0]       ram_rdata;

   logic                    req_fire;
   logic                    rsp_fire;
   logic                    too_large;
   logic [SUM_W-1:0]        fill_sum;
   logic                    fits;
   logic [CNT_W-1:0]        idx_plus_one;
   logic                    last_open;
   logic                    arena_full;

   // Fill of every chunk, written when opened or bumped.
   ffba_ram #(
      .WIDTH (FILL_W),
      .DEPTH (MAX_CHUNKS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Handshakes.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = (state_ff == ST_RESP);
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   // Shared compare unit: one chunk fill against the stored size per cycle.
   assign too_large    = (32'(req_ch.request_size) >= 32'(CHUNK_BYTES));
   assign fill_sum     = SUM_W'(ram_rdata) + SUM_W'(size_ff);
   assign fits         = (32'(fill_sum) < 32'(CHUNK_BYTES));
   assign idx_plus_one = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_open    = (idx_plus_one == count_ff);
   assign arena_full   = (count_ff == CNT_W'(MAX_CHUNKS));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (op_type'(req_ch.op) == OP_CLEAR || too_large ||
                   count_ff == '0) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (fits || last_open) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, RAM control and response values.
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      size_in    = size_ff;
      status_in  = status_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_off_in = rsp_off_ff;
      ram_we     = 1'b0;
      ram_waddr  = idx_ff;
      ram_wdata  = ram_rdata;
      ram_raddr  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // The first chunk is read ahead so a scan can start at once.
            ram_raddr = '0;
            if (req_fire) begin
               size_in    = req_ch.request_size;
               idx_in     = '0;
               rsp_idx_in = '0;
               rsp_off_in = '0;
               priority if (op_type'(req_ch.op) == OP_CLEAR) begin
                  count_in  = '0;
                  status_in = STATUS_CLEARED;
               end else if (too_large) begin
                  status_in = STATUS_TOO_LARGE;
               end else if (count_ff == '0) begin
                  // No chunk open yet: open chunk zero.
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = FILL_W'(req_ch.request_size);
                  count_in  = CNT_W'(1);
                  status_in = STATUS_GRANTED;
               end else begin
                  // Any other allocate starts a scan at chunk zero.
               end
            end
         end
         ST_SCAN: begin
            // Read the following chunk while this one is checked.
            ram_raddr = IDX_W'(idx_plus_one);
            priority if (fits) begin
               ram_we     = 1'b1;
               ram_waddr  = idx_ff;
               ram_wdata  = FILL_W'(fill_sum);
               status_in  = STATUS_GRANTED;
               rsp_idx_in = INDEX_W'(idx_ff);
               rsp_off_in = OFFSET_W'(ram_rdata);
            end else if (!last_open) begin
               idx_in = IDX_W'(idx_plus_one);
            end else if (arena_full) begin
               status_in = STATUS_FULL;
            end else begin
               // Open the next chunk, granted at offset zero.
               ram_we     = 1'b1;
               ram_waddr  = IDX_W'(count_ff);
               ram_wdata  = FILL_W'(size_ff);
               count_in   = count_ff + CNT_W'(1);
               status_in  = STATUS_GRANTED;
               rsp_idx_in = INDEX_W'(count_ff);
               rsp_off_in = '0;
            end
         end
         ST_RESP: begin
            ram_raddr = '0;
         end
         default: begin
            ram_raddr = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      size_ff    <= size_in;
      status_ff  <= status_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_off_ff <= rsp_off_in;
   end

   // Response payload.
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.chunk_index = rsp_idx_ff;
   assign rsp_ch.byte_offset = rsp_off_ff;

endmodule

>>> tb/tb_first_fit_chunk_bump_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_chunk_bump_allocator_core: self-checking bench of the allocator.
// A directed table covers the field extremes, clears, zero-size requests and
// exact-fit boundaries. Random phases under different idle patterns follow.
// Each accepted item is run through a local first-fit arena model. Each
// response is checked field by field against the oldest expected placement.
// ----------------------------------------------------------------------------
module tb_first_fit_chunk_bump_allocator_core import ffba_pkg::*; ();

   // Expected response of one item.
   typedef struct packed {
      status_type                status;
      logic [INDEX_W-1:0]        chunk_index;
      logic [OFFSET_W-1:0]       byte_offset;
   } placement_type;

   // One row of the directed table; typed rows carry their own answer.
   typedef struct {
      op_type                    op;
      logic [REQ_W-1:0]          size;
      bit                        typed;
      placement_type             want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 20;
   localparam int PHASE_ITEMS   = 140;
   localparam int HOLD_CYCLES   = 400;
   localparam int CLEAR_LEVEL   = 40;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_GAP       = 30;

   localparam placement_type NO_ANSWER = '{STATUS_GRANTED, '0, '0};

   // The request-too-large status cannot be provoked here: a 12-bit size never
   // reaches the chunk size of this arena.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_CLEAR, 12'h000, 1'b1, '{STATUS_CLEARED, 10'd0, 12'd0}},
      '{OP_ALLOC, 12'h000, 1'b1, '{STATUS_GRANTED, 10'd0, 12'd0}},
      '{OP_ALLOC, 12'hFFF, 1'b1, '{STATUS_GRANTED, 10'd0, 12'd0}},
      '{OP_ALLOC, 12'h000, 1'b1, '{STATUS_GRANTED, 10'd0, 12'd4095}},
      '{OP_ALLOC, 12'h001, 1'b1, '{STATUS_GRANTED, 10'd1, 12'd0}},
      '{OP_ALLOC, 12'hFFE, 1'b1, '{STATUS_GRANTED, 10'd1, 12'd1}},
      '{OP_ALLOC, 12'h800, 1'b1, '{STATUS_GRANTED, 10'd2, 12'd0}},
      '{OP_ALLOC, 12'h7FF, 1'b1, '{STATUS_GRANTED, 10'd2, 12'd2048}},
      '{OP_ALLOC, 12'hFFF, 1'b1, '{STATUS_GRANTED, 10'd3, 12'd0}},
      '{OP_CLEAR, 12'hFFF, 1'b1, '{STATUS_CLEARED, 10'd0, 12'd0}},
      '{OP_ALLOC, 12'hAAA, 1'b1, '{STATUS_GRANTED, 10'd0, 12'd0}},
      '{OP_ALLOC, 12'h555, 1'b1, '{STATUS_GRANTED, 10'd0, 12'hAAA}},
      '{OP_ALLOC, 12'h800, 1'b0, NO_ANSWER},
      '{OP_ALLOC, 12'h7FF, 1'b0, NO_ANSWER},
      '{OP_ALLOC, 12'h001, 1'b0, NO_ANSWER},
      '{OP_ALLOC, 12'h100, 1'b0, NO_ANSWER},
      '{OP_ALLOC, 12'h000, 1'b0, NO_ANSWER},
      '{OP_ALLOC, 12'hEFE, 1'b0, NO_ANSWER},
      '{OP_CLEAR, 12'h000, 1'b0, NO_ANSWER},
      '{OP_ALLOC, 12'h3FF, 1'b0, NO_ANSWER}
   };

   logic clock;
   logic reset;

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   first_fit_chunk_bump_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Arena model state.
   int arena_open_chunks;
   int arena_fill [MAX_CHUNKS];

   // Placements still owed by the block, oldest first.
   placement_type pending_placements [$];

   // Side information that travels with the item on the request channel.
   logic          item_typed;
   placement_type item_want;

   int fault_count;
   int result_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int hold_left;

   // First-fit placement of one request; updates the arena model.
   function automatic placement_type place_request(input op_type op,
                                                   input logic [REQ_W-1:0] size);
      placement_type r;
      int            k;
      bit            found;
      r     = '{STATUS_CLEARED, '0, '0};
      found = 1'b0;
      if (op == OP_CLEAR) begin
         arena_open_chunks = 0;
         return r;
      end
      if (int'(size) >= CHUNK_BYTES) begin
         r.status = STATUS_TOO_LARGE;
         return r;
      end
      for (k = 0; k < arena_open_chunks && !found; k++) begin
         if (arena_fill[k] + int'(size) < CHUNK_BYTES) begin
            r.status      = STATUS_GRANTED;
            r.chunk_index = INDEX_W'(k);
            r.byte_offset = OFFSET_W'(arena_fill[k]);
            arena_fill[k] = arena_fill[k] + int'(size);
            found         = 1'b1;
         end
      end
      if (!found) begin
         if (arena_open_chunks >= MAX_CHUNKS) begin
            r.status = STATUS_FULL;
         end else begin
            r.status                      = STATUS_GRANTED;
            r.chunk_index                 = INDEX_W'(arena_open_chunks);
            r.byte_offset                 = '0;
            arena_fill[arena_open_chunks] = int'(size);
            arena_open_chunks             = arena_open_chunks + 1;
         end
      end
      return r;
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #(100_000_000);
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off when one is asked for.
   initial begin
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Checking: responses against the oldest expectation, then new requests.
   always @(posedge clock) begin
      placement_type got;
      placement_type exp;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status      = status_type'(rsp_ch.status);
            got.chunk_index = rsp_ch.chunk_index;
            got.byte_offset = rsp_ch.byte_offset;
            if (pending_placements.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected response: status %0d index %0d offset %0d",
                           got.status, got.chunk_index, got.byte_offset);
            end else begin
               exp = pending_placements.pop_front();
               if (got.status !== exp.status || got.chunk_index !== exp.chunk_index ||
                   got.byte_offset !== exp.byte_offset) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"response %0d mismatch: expected status %0d index %0d ",
                               "offset %0d, got status %0d index %0d offset %0d"},
                              result_count, exp.status, exp.chunk_index,
                              exp.byte_offset, got.status, got.chunk_index,
                              got.byte_offset);
               end
            end
            result_count++;
         end
         if (req_ch.valid && req_ch.ready) begin
            exp = place_request(op_type'(req_ch.op), req_ch.request_size);
            if (item_typed)
               pending_placements.push_back(item_want);
            else
               pending_placements.push_back(exp);
         end
      end
   end

   // Offers one item after a random gap and returns at the edge it is taken.
   task automatic offer_item(input op_type op, input logic [REQ_W-1:0] size,
                             input logic typed, input placement_type want);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= op;
      req_ch.request_size <= size;
      item_typed          <= typed;
      item_want           <= want;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops offering until every owed response has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_placements.size() != 0)
         @(posedge clock);
   endtask

   // Picks a random item. Mostly allocations of small, random or large sizes,
   // some aimed at the fit boundary of an open chunk; a clear keeps the scans short.
   task automatic pick_random_item(output op_type op, output logic [REQ_W-1:0] size);
      int roll;
      int k;
      int room;
      roll = $urandom_range(0, 99);
      op   = OP_ALLOC;
      size = REQ_W'($urandom_range(0, 4095));
      if (arena_open_chunks >= CLEAR_LEVEL || roll < 5) begin
         op = OP_CLEAR;
      end else if (roll < 35) begin
         size = REQ_W'($urandom_range(0, 255));
      end else if (roll < 60) begin
         size = REQ_W'($urandom_range(0, 4095));
      end else if (roll < 75) begin
         size = REQ_W'($urandom_range(3800, 4095));
      end else if (roll < 95 && arena_open_chunks > 0) begin
         // Exactly fits, or misses by one byte.
         k    = $urandom_range(0, arena_open_chunks - 1);
         room = CHUNK_BYTES - arena_fill[k] - $urandom_range(0, 1);
         if (room > CHUNK_BYTES - 1)
            room = CHUNK_BYTES - 1;
         if (room < 0)
            room = 0;
         size = REQ_W'(room);
      end else begin
         size = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end
   endtask

   // Stimulus.
   initial begin
      op_type           op;
      logic [REQ_W-1:0] size;
      int               phase;
      int               n;
      int               i;
      fault_count         = 0;
      result_count        = 0;
      arena_open_chunks   = 0;
      hold_request        = 0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= OP_ALLOC;
      req_ch.request_size <= '0;
      item_typed          <= 1'b0;
      item_want           <= NO_ANSWER;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (i = 0; i < DIRECTED_ROWS; i++)
         offer_item(directed_rows[i].op, directed_rows[i].size,
                    directed_rows[i].typed, directed_rows[i].want);
      wait_for_results();

      // Random phases: no idling, idle sender, stalling receiver, both.
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 26 : 0;
         recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 26 : 0;
         // Long hold-off on the response side while items keep coming.
         if (phase == 0)
            hold_request = 1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick_random_item(op, size);
            offer_item(op, size, 1'b0, NO_ANSWER);
            if ($urandom_range(0, 49) == 0)
               wait_for_results();
         end
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
